// ===== rtl/core/dapqm_pkg.sv =====
package dapqm_pkg;

  // field widths
  localparam int ANGLE_WIDTH = 16;
  localparam int GAIN_W      = 24;
  localparam int LEVEL_W     = 8;
  localparam int TICKS_W     = 10;
  localparam int FRAC_W      = 24;
  localparam int INTEG_W     = 48;
  localparam int CFG_INDEX_W = 4;
  localparam int CFG_DATA_W  = 24;

  // datapath widths, all exact for the products and sums they carry
  localparam int DIFF_W  = ANGLE_WIDTH + 1;
  localparam int PROD_W  = GAIN_W + 1 + ANGLE_WIDTH;
  localparam int DPROD_W = GAIN_W + 1 + DIFF_W;
  localparam int PD_W    = DPROD_W + 1;
  localparam int ISUM_W  = ((PROD_W > INTEG_W) ? PROD_W : INTEG_W) + 1;
  localparam int U_W     = ((PD_W > INTEG_W) ? PD_W : INTEG_W) + 1;
  localparam int MIX_W   = U_W + 1;
  localparam int V_W     = MIX_W + 1;

  // register reset values
  localparam logic [GAIN_W-1:0]  KP_RESET        = 24'd65536;
  localparam logic [GAIN_W-1:0]  KI_RESET        = 24'd66;
  localparam logic [GAIN_W-1:0]  KD_RESET        = 24'd655360;
  localparam logic [LEVEL_W-1:0] BASE_RESET      = 8'd60;
  localparam logic [LEVEL_W-1:0] MIN_RESET       = 8'd60;
  localparam logic [LEVEL_W-1:0] MAX_RESET       = 8'd102;
  localparam logic [LEVEL_W-1:0] ARM_LEVEL_RESET = 8'd52;
  localparam logic [TICKS_W-1:0] ARM_TICKS_RESET = 10'd300;

  // register indexes
  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_KP        = 4'd0,
    REG_KI        = 4'd1,
    REG_KD        = 4'd2,
    REG_BASE      = 4'd3,
    REG_MIN       = 4'd4,
    REG_MAX       = 4'd5,
    REG_ARM_LEVEL = 4'd6,
    REG_ARM_TICKS = 4'd7
  } cfg_reg_t;

  typedef struct packed {
    logic [GAIN_W-1:0]  kp_gain;
    logic [GAIN_W-1:0]  ki_gain;
    logic [GAIN_W-1:0]  kd_rate_gain;
    logic [LEVEL_W-1:0] base_level;
    logic [LEVEL_W-1:0] min_level;
    logic [LEVEL_W-1:0] max_level;
    logic [LEVEL_W-1:0] arm_level;
    logic [TICKS_W-1:0] arm_ticks;
  } cfg_t;

  typedef struct packed {
    logic signed [ANGLE_WIDTH-1:0] pitch_angle;
    logic signed [ANGLE_WIDTH-1:0] roll_angle;
  } angle_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] motor_rf;
    logic [LEVEL_W-1:0] motor_rb;
    logic [LEVEL_W-1:0] motor_lf;
    logic [LEVEL_W-1:0] motor_lb;
    logic               is_armed;
  } cmd_t;

  // stage load strobes shared by both axes
  typedef struct packed {
    logic s1_load;
    logic s2_load;
    logic s3_load;
    logic s4_load;
  } stage_ctrl_t;

endpackage

// ===== rtl/core/dapqm_axis_pid.sv =====
module dapqm_axis_pid (
  input  logic                                   clk,
  input  logic                                   rst,
  input  dapqm_pkg::stage_ctrl_t                 ctrl,
  input  dapqm_pkg::cfg_t                        cfg,
  input  logic signed [dapqm_pkg::ANGLE_WIDTH-1:0] angle,
  output logic signed [dapqm_pkg::U_W-1:0]       u
);

  localparam int INTEG_W = dapqm_pkg::INTEG_W;
  localparam int ISUM_W  = dapqm_pkg::ISUM_W;
  localparam int PD_W    = dapqm_pkg::PD_W;
  localparam int U_W     = dapqm_pkg::U_W;

  localparam logic signed [INTEG_W-1:0] INTEG_MAX = {1'b0, {(INTEG_W-1){1'b1}}};
  localparam logic signed [INTEG_W-1:0] INTEG_MIN = {1'b1, {(INTEG_W-1){1'b0}}};

  logic signed [dapqm_pkg::ANGLE_WIDTH-1:0] last_error;
  logic signed [dapqm_pkg::ANGLE_WIDTH-1:0] e1;
  logic signed [dapqm_pkg::DIFF_W-1:0]      diff1;
  logic signed [dapqm_pkg::PROD_W-1:0]      p2;
  logic signed [dapqm_pkg::PROD_W-1:0]      i2;
  logic signed [dapqm_pkg::DPROD_W-1:0]     d2;
  logic signed [PD_W-1:0]                   pd3;
  logic signed [INTEG_W-1:0]                integ;
  logic signed [INTEG_W-1:0]                integ_next;
  logic signed [ISUM_W-1:0]                 isum;
  logic [ISUM_W-INTEG_W:0]                  isum_hi;
  logic signed [U_W-1:0]                    u4;

  // saturating integrator update
  assign isum    = ISUM_W'(i2) + ISUM_W'(integ);
  assign isum_hi = isum[ISUM_W-1:INTEG_W-1];

  always_comb begin
    if ((&isum_hi) || !(|isum_hi)) begin
      integ_next = isum[INTEG_W-1:0];
    end else if (isum[ISUM_W-1]) begin
      integ_next = INTEG_MIN;
    end else begin
      integ_next = INTEG_MAX;
    end
  end

  // error history and integral state
  always_ff @(posedge clk) begin
    if (rst) begin
      last_error <= '0;
      integ      <= '0;
    end else begin
      if (ctrl.s1_load) begin
        last_error <= angle;
      end
      if (ctrl.s3_load) begin
        integ <= integ_next;
      end
    end
  end

  // pipeline payload: input, products, partial sum, axis output
  always_ff @(posedge clk) begin
    if (ctrl.s1_load) begin
      e1    <= angle;
      diff1 <= dapqm_pkg::DIFF_W'(angle) - dapqm_pkg::DIFF_W'(last_error);
    end
    if (ctrl.s2_load) begin
      p2 <= dapqm_pkg::PROD_W'($signed({1'b0, cfg.kp_gain})) * dapqm_pkg::PROD_W'(e1);
      i2 <= dapqm_pkg::PROD_W'($signed({1'b0, cfg.ki_gain})) * dapqm_pkg::PROD_W'(e1);
      d2 <= dapqm_pkg::DPROD_W'($signed({1'b0, cfg.kd_rate_gain}))
            * dapqm_pkg::DPROD_W'(diff1);
    end
    if (ctrl.s3_load) begin
      pd3 <= PD_W'(p2) + PD_W'(d2);
    end
    if (ctrl.s4_load) begin
      u4 <= U_W'(pd3) + U_W'(integ);
    end
  end

  assign u = u4;

endmodule

// ===== rtl/core/dual_axis_pid_quad_mixer.sv =====
// Dual-axis PID attitude controller with quadcopter motor mixer.
// Angle channel (angle_valid, angle_stall, angle): one item holds the pitch and
// roll errors, signed Q8.8. Command channel (cmd_valid, cmd_stall, cmd): one
// item per angle item, four 8-bit motor commands and the armed flag, in order.
// Configuration channel (cfg_valid, cfg_ready, cfg_index, cfg_data): cfg_ready
// is always high; indexes beyond the register list are ignored. Write it only
// while no item is in flight.
// Path: the input register loads at the accepting edge, then the product,
// partial-sum, axis-sum and output registers follow; a command item is
// offered from the output register. Throughput: one item per cycle while
// cmd_stall is low; each stage advances independently, so bubbles close up
// and a new item is taken while a command waits.
// When the receiver stalls, the command register holds and the stages behind
// it fill, then angle_stall rises; nothing is dropped.
// Reset clears the integrators, the last errors and the arming counter and
// loads every configuration register with its default. The first arm_ticks
// items give arm_level on all motors with is_armed low.
module dual_axis_pid_quad_mixer (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   angle_valid,
  output logic                                   angle_stall,
  input  dapqm_pkg::angle_t                      angle,
  output logic                                   cmd_valid,
  input  logic                                   cmd_stall,
  output dapqm_pkg::cmd_t                        cmd,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [dapqm_pkg::CFG_INDEX_W-1:0]      cfg_index,
  input  logic [dapqm_pkg::CFG_DATA_W-1:0]       cfg_data
);

  localparam int LEVEL_W = dapqm_pkg::LEVEL_W;
  localparam int FRAC_W  = dapqm_pkg::FRAC_W;
  localparam int MIX_W   = dapqm_pkg::MIX_W;
  localparam int V_W     = dapqm_pkg::V_W;
  localparam int U_W     = dapqm_pkg::U_W;

  dapqm_pkg::cfg_t        cfg;
  dapqm_pkg::stage_ctrl_t ctrl;
  dapqm_pkg::cmd_t        cmd_next;

  logic [dapqm_pkg::TICKS_W-1:0] arm_count;
  logic v1, v2, v3, v4;
  logic armed1, armed2, armed3, armed4;
  logic ready1, ready2, ready3, ready4, ready_out;
  logic arming;
  logic signed [U_W-1:0]   pitch_u, roll_u;
  logic signed [MIX_W-1:0] mix_rf, mix_rb, mix_lf, mix_lb;

  // clamp one mixed value around the base level
  function automatic logic [LEVEL_W-1:0] motor_level(
    input logic signed [MIX_W-1:0] mix,
    input logic [LEVEL_W-1:0]      base,
    input logic [LEVEL_W-1:0]      lo,
    input logic [LEVEL_W-1:0]      hi
  );
    logic signed [V_W-1:0] v;
    logic signed [V_W-1:0] lo_v;
    logic signed [V_W-1:0] hi_v;
    logic [LEVEL_W-1:0]    r;
    v    = V_W'(mix) + $signed(V_W'({base, {FRAC_W{1'b0}}}));
    lo_v = $signed(V_W'({lo, {FRAC_W{1'b0}}}));
    hi_v = $signed(V_W'({hi, {FRAC_W{1'b0}}}));
    priority if (v > hi_v) begin
      r = hi;
    end else if (v < lo_v) begin
      r = lo;
    end else begin
      r = v[FRAC_W+LEVEL_W-1:FRAC_W];
    end
    return r;
  endfunction

  // configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.kp_gain      <= dapqm_pkg::KP_RESET;
      cfg.ki_gain      <= dapqm_pkg::KI_RESET;
      cfg.kd_rate_gain <= dapqm_pkg::KD_RESET;
      cfg.base_level   <= dapqm_pkg::BASE_RESET;
      cfg.min_level    <= dapqm_pkg::MIN_RESET;
      cfg.max_level    <= dapqm_pkg::MAX_RESET;
      cfg.arm_level    <= dapqm_pkg::ARM_LEVEL_RESET;
      cfg.arm_ticks    <= dapqm_pkg::ARM_TICKS_RESET;
    end else if (cfg_valid) begin
      unique case (dapqm_pkg::cfg_reg_t'(cfg_index))
        dapqm_pkg::REG_KP:        cfg.kp_gain      <= cfg_data[dapqm_pkg::GAIN_W-1:0];
        dapqm_pkg::REG_KI:        cfg.ki_gain      <= cfg_data[dapqm_pkg::GAIN_W-1:0];
        dapqm_pkg::REG_KD:        cfg.kd_rate_gain <= cfg_data[dapqm_pkg::GAIN_W-1:0];
        dapqm_pkg::REG_BASE:      cfg.base_level   <= cfg_data[LEVEL_W-1:0];
        dapqm_pkg::REG_MIN:       cfg.min_level    <= cfg_data[LEVEL_W-1:0];
        dapqm_pkg::REG_MAX:       cfg.max_level    <= cfg_data[LEVEL_W-1:0];
        dapqm_pkg::REG_ARM_LEVEL: cfg.arm_level    <= cfg_data[LEVEL_W-1:0];
        dapqm_pkg::REG_ARM_TICKS: cfg.arm_ticks    <= cfg_data[dapqm_pkg::TICKS_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // stage flow: a stage takes a new item when empty or when it moves on
  assign ready_out   = !cmd_valid || !cmd_stall;
  assign ready4      = !v4 || ready_out;
  assign ready3      = !v3 || ready4;
  assign ready2      = !v2 || ready3;
  assign ready1      = !v1 || ready2;
  assign angle_stall = !ready1;

  assign ctrl.s1_load = angle_valid && ready1;
  assign ctrl.s2_load = v1 && ready2;
  assign ctrl.s3_load = v2 && ready3;
  assign ctrl.s4_load = v3 && ready4;

  assign arming = arm_count < cfg.arm_ticks;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      v4        <= 1'b0;
      cmd_valid <= 1'b0;
      arm_count <= '0;
    end else begin
      if (ready1) v1 <= angle_valid;
      if (ready2) v2 <= v1;
      if (ready3) v3 <= v2;
      if (ready4) v4 <= v3;
      if (ready_out) cmd_valid <= v4;
      if (ctrl.s1_load && arming) begin
        arm_count <= arm_count + 1'b1;
      end
    end
  end

  // armed flag travels with its item
  always_ff @(posedge clk) begin
    if (ctrl.s1_load) armed1 <= !arming;
    if (ctrl.s2_load) armed2 <= armed1;
    if (ctrl.s3_load) armed3 <= armed2;
    if (ctrl.s4_load) armed4 <= armed3;
  end

  // per-axis PID pipelines
  dapqm_axis_pid u_pitch (
    .clk   (clk),
    .rst   (rst),
    .ctrl  (ctrl),
    .cfg   (cfg),
    .angle (angle.pitch_angle),
    .u     (pitch_u)
  );

  dapqm_axis_pid u_roll (
    .clk   (clk),
    .rst   (rst),
    .ctrl  (ctrl),
    .cfg   (cfg),
    .angle (angle.roll_angle),
    .u     (roll_u)
  );

  // quad mixer
  assign mix_rf = -MIX_W'(roll_u) - MIX_W'(pitch_u);
  assign mix_rb = -MIX_W'(roll_u) + MIX_W'(pitch_u);
  assign mix_lf =  MIX_W'(roll_u) - MIX_W'(pitch_u);
  assign mix_lb =  MIX_W'(roll_u) + MIX_W'(pitch_u);

  always_comb begin
    if (armed4) begin
      cmd_next.motor_rf = motor_level(mix_rf, cfg.base_level, cfg.min_level, cfg.max_level);
      cmd_next.motor_rb = motor_level(mix_rb, cfg.base_level, cfg.min_level, cfg.max_level);
      cmd_next.motor_lf = motor_level(mix_lf, cfg.base_level, cfg.min_level, cfg.max_level);
      cmd_next.motor_lb = motor_level(mix_lb, cfg.base_level, cfg.min_level, cfg.max_level);
      cmd_next.is_armed = 1'b1;
    end else begin
      cmd_next.motor_rf = cfg.arm_level;
      cmd_next.motor_rb = cfg.arm_level;
      cmd_next.motor_lf = cfg.arm_level;
      cmd_next.motor_lb = cfg.arm_level;
      cmd_next.is_armed = 1'b0;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (ready_out && v4) begin
      cmd <= cmd_next;
    end
  end

endmodule
